### hdl/ssg_pkg.sv
// ----------------------------------------------------------------------------
// ssg_pkg
// shared widths, register indexes, status codes and constants of the
// sampled sine generator
// ----------------------------------------------------------------------------
`default_nettype none

package ssg_pkg;

  localparam int TIME_W    = 31;
  localparam int COUNT_W   = 16;
  localparam int RATE_W    = 31;
  localparam int PHASE_W   = 20;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int NUM_W     = COUNT_W + TIME_W;
  localparam int QUO_W     = TIME_W;
  localparam int PROD_W    = RATE_W + TIME_W;
  localparam int RED_W     = 35;
  localparam int MOD_N     = PROD_W - RED_W + 1;
  localparam int PH_W      = 22;
  localparam int CORDIC_W  = 34;
  localparam int MULT_W    = 2 * VALUE_W;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_ENTRIES    = 30;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AMP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DC    = 3'd6;

  localparam logic [RED_W-1:0]           TWO_PI_Q32  = 35'd26986075409;
  localparam logic signed [PH_W-1:0]     PI_Q16      = 22'sd205887;
  localparam logic signed [PH_W-1:0]     TWO_PI_Q16  = 22'sd411775;
  localparam logic signed [PH_W-1:0]     HALF_PI_Q16 = 22'sd102944;
  localparam logic signed [CORDIC_W-1:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   tim;
  } ssg_side_t;

  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'd843314857;
      1:  a = 32'd497837829;
      2:  a = 32'd263043837;
      3:  a = 32'd133525159;
      4:  a = 32'd67021687;
      5:  a = 32'd33543516;
      6:  a = 32'd16775851;
      7:  a = 32'd8388437;
      8:  a = 32'd4194283;
      9:  a = 32'd2097149;
      10: a = 32'd1048576;
      11: a = 32'd524288;
      12: a = 32'd262144;
      13: a = 32'd131072;
      14: a = 32'd65536;
      15: a = 32'd32768;
      16: a = 32'd16384;
      17: a = 32'd8192;
      18: a = 32'd4096;
      19: a = 32'd2048;
      20: a = 32'd1024;
      21: a = 32'd512;
      22: a = 32'd256;
      23: a = 32'd128;
      24: a = 32'd64;
      25: a = 32'd32;
      26: a = 32'd16;
      27: a = 32'd8;
      28: a = 32'd4;
      29: a = 32'd2;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### hdl/ssg_div_cell.sv
// ----------------------------------------------------------------------------
// ssg_div_cell
// one restoring division step: yields one quotient bit per cell
// ----------------------------------------------------------------------------
`default_nettype none

module ssg_div_cell import ssg_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [NUM_W-1:0]   rem_i,
  input  wire logic [QUO_W-1:0]   quo_i,
  input  wire logic [COUNT_W-1:0] den_i,
  output logic      [NUM_W-1:0]   rem_o,
  output logic      [QUO_W-1:0]   quo_o
);

  logic [NUM_W-1:0] den_sh;
  logic             ge;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;

  always_comb begin
    den_sh  = NUM_W'(den_i) << SHIFT;
    ge      = rem_i >= den_sh;
    rem_nxt = ge ? rem_i - den_sh : rem_i;
    quo_nxt = {quo_i[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

`default_nettype wire

### hdl/ssg_mod_cell.sv
// ----------------------------------------------------------------------------
// ssg_mod_cell
// one step of the reduction modulo two pi (Q32)
// ----------------------------------------------------------------------------
`default_nettype none

module ssg_mod_cell import ssg_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [PROD_W-1:0] rem_i,
  output logic      [PROD_W-1:0] rem_o
);

  localparam logic [PROD_W-1:0] K_SH = PROD_W'(TWO_PI_Q32) << SHIFT;

  logic [PROD_W-1:0] rem_r, rem_nxt;

  assign rem_nxt = (rem_i >= K_SH) ? rem_i - K_SH : rem_i;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
    end
  end

  assign rem_o = rem_r;

endmodule

`default_nettype wire

### hdl/ssg_cordic_cell.sv
// ----------------------------------------------------------------------------
// ssg_cordic_cell
// one rotation-mode cordic micro-rotation
// ----------------------------------------------------------------------------
`default_nettype none

module ssg_cordic_cell import ssg_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [CORDIC_W-1:0] x_i,
  input  wire logic signed [CORDIC_W-1:0] y_i,
  input  wire logic signed [CORDIC_W-1:0] z_i,
  output logic signed      [CORDIC_W-1:0] x_o,
  output logic signed      [CORDIC_W-1:0] y_o,
  output logic signed      [CORDIC_W-1:0] z_o
);

  localparam logic signed [CORDIC_W-1:0] ANG = CORDIC_W'(atan_q30(STEP));

  logic signed [CORDIC_W-1:0] xs, ys;
  logic signed [CORDIC_W-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (z_i >= 0) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ANG;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

`default_nettype wire

### hdl/sampled_sine_generator.sv
// ----------------------------------------------------------------------------
// sampled_sine_generator
// sample time and sine value for a sample index, fully pipelined
//
//   channel  direction  beat
//   in_      in         sample_index
//   out_     out        sample_time, sample_value, status
//   cfg_     in         register index and write data
//
// one beat per clock in and out while the output is not stalled, through
// the 31 divider cells, the 28 modulo cells and the cordic cells in a row
// synchronous active-low reset clears all valid bits and loads the
// register defaults
// a stalled output beat freezes the whole row of cells; in_ready follows
// ----------------------------------------------------------------------------
`default_nettype none

module sampled_sine_generator import ssg_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [COUNT_W-1:0]         in_sample_index,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [TIME_W-1:0]               out_sample_time,
  output logic signed [VALUE_W-1:0]       out_sample_value,
  output logic [STATUS_W-1:0]             out_status,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DAT_W-1:0]       cfg_data
);

  localparam int POS_T    = QUO_W + 1;
  localparam int POS_MUL  = POS_T + 1;
  localparam int POS_PH   = POS_MUL + MOD_N + 1;
  localparam int POS_PROD = POS_PH + CORDIC_STEPS + 1;
  localparam int LAST     = POS_PROD;

  // configuration registers
  logic [TIME_W-1:0]         start_time_r, stop_time_r;
  logic [COUNT_W-1:0]        point_count_r;
  logic [RATE_W-1:0]         angular_rate_r;
  logic signed [PHASE_W-1:0] start_phase_r;
  logic signed [VALUE_W-1:0] peak_amplitude_r, dc_offset_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r     <= '0;
      stop_time_r      <= TIME_W'(65536);
      point_count_r    <= COUNT_W'(1000);
      angular_rate_r   <= RATE_W'(65536);
      start_phase_r    <= '0;
      peak_amplitude_r <= VALUE_W'(65536);
      dc_offset_r      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START: start_time_r     <= cfg_data[TIME_W-1:0];
        REG_STOP:  stop_time_r      <= cfg_data[TIME_W-1:0];
        REG_COUNT: point_count_r    <= cfg_data[COUNT_W-1:0];
        REG_RATE:  angular_rate_r   <= cfg_data[RATE_W-1:0];
        REG_PHASE: start_phase_r    <= cfg_data[PHASE_W-1:0];
        REG_AMP:   peak_amplitude_r <= cfg_data[VALUE_W-1:0];
        REG_DC:    dc_offset_r      <= cfg_data[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // sideband row
  logic      vld_r  [0:LAST];
  ssg_side_t side_r [0:LAST];
  ssg_side_t side_in[1:LAST];
  ssg_side_t side0_nxt;
  logic [NUM_W-1:0]  num_r;
  logic [QUO_W-1:0]  quo_fin;
  logic [TIME_W-1:0] span;

  assign span = stop_time_r - start_time_r;

  always_comb begin
    if (start_time_r >= stop_time_r) begin
      side0_nxt.status = ST_RANGE;
    end else if (in_sample_index >= point_count_r) begin
      side0_nxt.status = ST_INDEX;
    end else begin
      side0_nxt.status = ST_OK;
    end
    side0_nxt.tim = '0;
  end

  always_comb begin
    for (int i = 1; i <= LAST; i++) begin
      side_in[i] = side_r[i-1];
    end
    side_in[POS_T].tim = start_time_r + quo_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LAST; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i <= LAST; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side0_nxt;
      num_r     <= NUM_W'(in_sample_index) * NUM_W'(span);
      for (int i = 1; i <= LAST; i++) begin
        side_r[i] <= side_in[i];
      end
    end
  end

  // divider cells
  logic [NUM_W-1:0] div_rem[0:QUO_W];
  logic [QUO_W-1:0] div_quo[0:QUO_W];

  assign div_rem[0] = num_r;
  assign div_quo[0] = '0;
  assign quo_fin    = div_quo[QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    ssg_div_cell #(.SHIFT(QUO_W - 1 - j)) u_cell (
      .clk  (clk),
      .en   (adv),
      .rem_i(div_rem[j]),
      .quo_i(div_quo[j]),
      .den_i(point_count_r),
      .rem_o(div_rem[j+1]),
      .quo_o(div_quo[j+1])
    );
  end

  // phase product and modulo cells
  logic [PROD_W-1:0] mod_rem[0:MOD_N];
  logic [PROD_W-1:0] wt_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      wt_r <= PROD_W'(angular_rate_r) * PROD_W'(side_r[POS_T].tim);
    end
  end

  assign mod_rem[0] = wt_r;

  for (genvar j = 0; j < MOD_N; j++) begin : g_mod
    ssg_mod_cell #(.SHIFT(MOD_N - 1 - j)) u_cell (
      .clk  (clk),
      .en   (adv),
      .rem_i(mod_rem[j]),
      .rem_o(mod_rem[j+1])
    );
  end

  // wrap into [-pi, pi] and fold into [-pi/2, pi/2]
  logic signed [PH_W-1:0]     ph, ph_w, ph_f;
  logic signed [CORDIC_W-1:0] z_r, z_nxt;

  always_comb begin
    ph = $signed(PH_W'(mod_rem[MOD_N][RED_W-1:16])) + PH_W'(start_phase_r);
    priority if (ph > PI_Q16 + TWO_PI_Q16) begin
      ph_w = ph - TWO_PI_Q16 - TWO_PI_Q16;
    end else if (ph > PI_Q16) begin
      ph_w = ph - TWO_PI_Q16;
    end else if (ph < -PI_Q16 - TWO_PI_Q16) begin
      ph_w = ph + TWO_PI_Q16 + TWO_PI_Q16;
    end else if (ph < -PI_Q16) begin
      ph_w = ph + TWO_PI_Q16;
    end else begin
      ph_w = ph;
    end
    priority if (ph_w > HALF_PI_Q16) begin
      ph_f = PI_Q16 - ph_w;
    end else if (ph_w < -HALF_PI_Q16) begin
      ph_f = -PI_Q16 - ph_w;
    end else begin
      ph_f = ph_w;
    end
    z_nxt = CORDIC_W'(ph_f) <<< 14;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z_r <= z_nxt;
    end
  end

  // cordic cells
  logic signed [CORDIC_W-1:0] cx[0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cy[0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cz[0:CORDIC_STEPS];

  assign cx[0] = GAIN_Q30;
  assign cy[0] = '0;
  assign cz[0] = z_r;

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    ssg_cordic_cell #(.STEP(j)) u_cell (
      .clk(clk),
      .en (adv),
      .x_i(cx[j]),
      .y_i(cy[j]),
      .z_i(cz[j]),
      .x_o(cx[j+1]),
      .y_o(cy[j+1]),
      .z_o(cz[j+1])
    );
  end

  // amplitude scaling, offset and saturation
  logic signed [MULT_W-1:0]    amp_r;
  logic signed [MULT_W:0]      rnd_sum;
  logic signed [MULT_W-30:0]   scaled;
  logic signed [MULT_W-29:0]   val_sum;
  logic signed [VALUE_W-1:0]   val_sat;
  logic [TIME_W-1:0]           time_r;
  logic signed [VALUE_W-1:0]   value_r;
  logic [STATUS_W-1:0]         status_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      amp_r <= MULT_W'(peak_amplitude_r) * MULT_W'($signed(cy[CORDIC_STEPS][VALUE_W-1:0]));
    end
  end

  always_comb begin
    rnd_sum = (MULT_W+1)'(amp_r) + ((MULT_W+1)'(1) <<< 29);
    scaled  = rnd_sum[MULT_W:30];
    val_sum = (MULT_W-28)'(scaled) + (MULT_W-28)'(dc_offset_r);
    priority if (val_sum > (MULT_W-28)'(32'sh7fffffff)) begin
      val_sat = 32'sh7fffffff;
    end else if (val_sum < -(MULT_W-28)'(33'sh080000000)) begin
      val_sat = 32'sh80000000;
    end else begin
      val_sat = val_sum[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= side_r[LAST].status;
      if (side_r[LAST].status == ST_OK) begin
        time_r  <= side_r[LAST].tim;
        value_r <= val_sat;
      end else begin
        time_r  <= '0;
        value_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_time  = time_r;
  assign out_sample_value = value_r;
  assign out_status       = status_r;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_sample_time == '0 && out_sample_value == '0)
    else $error("error beat with non-zero payload");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_INDEX || out_status == ST_RANGE))
    else $error("unknown status code");

  a_time_below_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_sample_time < stop_time_r)
    else $error("sample time not below stop time");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");
`endif

endmodule

`default_nettype wire
